// ===== hw/rtl/pre_pkg.sv =====
// Shared types and constants of the polyline ribbon extruder.
// No dependencies; imported by the controller, datapath and top level.
package pre_pkg;

  localparam int unsigned CoordFracBitsDef = 12;
  localparam int unsigned LwWidth = 12;
  localparam int unsigned CoordWidth = 16;
  localparam logic signed [15:0] UnitOne = 16'sd16384;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps = 16;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_SHIFT,
    OP_LOAD,
    OP_CROSS_MUL,
    OP_CROSS_ACC,
    OP_VEC_LOAD,
    OP_HALVE,
    OP_SQ_MUL,
    OP_SQ_ACC,
    OP_SIDE_FALL,
    OP_SMOOTH_FALL,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_OFF_MUL,
    OP_OFF_ACC,
    OP_EMIT
  } pre_op_e;

  typedef struct packed {
    pre_op_e    op;
    logic [2:0] idx;      // component or product number
    logic       vsel;     // 0: side normal, 1: smooth normal
    logic       in_ready;
  } pre_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic       strip_start;
    logic [1:0] seen;
    logic       big;      // a magnitude still has bits at 2^20 or above
    logic       len_zero;
    logic       out_busy;
  } pre_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sd32767;
    end else if (v < -19'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pre_if.sv =====
// Valid/ready channel interfaces for points in and ribbon results out.
// No dependencies.
interface pre_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic               strip_start;

  modport source(output valid, point_x, point_y, point_z, strip_start, input ready);
  modport sink(input valid, point_x, point_y, point_z, strip_start, output ready);
endinterface

interface pre_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] upper_x;
  logic signed [15:0] upper_y;
  logic signed [15:0] upper_z;
  logic signed [15:0] lower_x;
  logic signed [15:0] lower_y;
  logic signed [15:0] lower_z;
  logic signed [15:0] smooth_x;
  logic signed [15:0] smooth_y;
  logic signed [15:0] smooth_z;
  logic               fell_back;

  modport source(output valid, upper_x, upper_y, upper_z, lower_x, lower_y, lower_z,
                 smooth_x, smooth_y, smooth_z, fell_back, input ready);
  modport sink(input valid, upper_x, upper_y, upper_z, lower_x, lower_y, lower_z,
               smooth_x, smooth_y, smooth_z, fell_back, output ready);
endinterface

// ===== hw/rtl/polyline_ribbon_extruder.sv =====
// Top level of the polyline ribbon extruder: controller plus datapath.
// Depends on pre_pkg, pre_if, pre_ctrl, pre_dp.
//
// Points enter one per item; a strip start or second point is absorbed with
// no result. Each later point yields one ribbon result, which turns valid
// after the cross product, then per normal a load, the halving and checks,
// squaring, a length check, the root setup, the root steps and a division
// per component, and last the offsets and the emit. A zero length skips
// straight to the offsets. The next point can be taken the cycle after the
// emit. The work is set by the single shared multiplier and the bit-serial
// square root, used once per normal, and divider, used once per component.
// One item is worked on at a time; the next point is taken while a finished
// result waits at the output, and the emit waits until it is gone.
module polyline_ribbon_extruder
  import pre_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = CoordFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LwWidth-1:0] cfg_wdata_i,
  pre_point_if.sink          pt_i,
  pre_result_if.source       res_o
);

  pre_cmd_t  cmd;
  pre_stat_t stat;

  pre_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  pre_dp #(
    .CoordFracBits(COORD_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .pt_i        (pt_i),
    .res_o       (res_o)
  );

endmodule

// ===== hw/rtl/pre_ctrl.sv =====
// Sequencer of the ribbon extruder: steps the datapath through cross
// product, two normalizations and offsets. Depends on pre_pkg.
module pre_ctrl
  import pre_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pre_stat_t stat_i,
  output pre_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CROSS, S_VLOAD, S_HALVE, S_SQ, S_CHECK, S_SQRT_INIT, S_SQRT,
    S_DIV_INIT, S_DIV, S_DIV_STORE, S_OFF, S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic       vsel_q, vsel_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    vsel_d  = vsel_q;
    cmd_o   = '{op: OP_NONE, idx: 3'd0, vsel: vsel_q, in_ready: 1'b0};
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          if (stat_i.strip_start || stat_i.seen == 2'd0) begin
            cmd_o.op = OP_START;
          end else if (stat_i.seen == 2'd1) begin
            cmd_o.op = OP_SHIFT;
          end else begin
            cmd_o.op = OP_LOAD;
            state_d  = S_CROSS;
            cnt_d    = '0;
            vsel_d   = 1'b0;
          end
        end
      end
      S_CROSS: begin
        cmd_o.op  = cnt_q[0] ? OP_CROSS_ACC : OP_CROSS_MUL;
        cmd_o.idx = cnt_q[3:1];
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'd11) begin
          state_d = S_VLOAD;
        end
      end
      S_VLOAD: begin
        cmd_o.op = OP_VEC_LOAD;
        state_d  = S_HALVE;
      end
      S_HALVE: begin
        if (stat_i.big) begin
          cmd_o.op = OP_HALVE;
        end else begin
          state_d = S_SQ;
          cnt_d   = '0;
        end
      end
      S_SQ: begin
        cmd_o.op  = cnt_q[0] ? OP_SQ_ACC : OP_SQ_MUL;
        cmd_o.idx = cnt_q[3:1];
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'd5) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.len_zero) begin
          // a failed side normal also forces the smooth fallback
          cmd_o.op = vsel_q ? OP_SMOOTH_FALL : OP_SIDE_FALL;
          state_d  = S_OFF;
          cnt_d    = '0;
        end else begin
          state_d = S_SQRT_INIT;
        end
      end
      S_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        state_d  = S_SQRT;
        cnt_d    = '0;
        comp_d   = '0;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'(SqrtSteps - 1)) begin
          state_d = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd_o.op  = OP_DIV_INIT;
        cmd_o.idx = {1'b0, comp_q};
        state_d   = S_DIV;
        cnt_d     = '0;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) begin
          state_d = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        cmd_o.op  = OP_DIV_STORE;
        cmd_o.idx = {1'b0, comp_q};
        comp_d    = comp_q + 2'd1;
        if (comp_q != 2'd2) begin
          state_d = S_DIV_INIT;
        end else if (!vsel_q) begin
          vsel_d  = 1'b1;
          state_d = S_VLOAD;
        end else begin
          state_d = S_OFF;
          cnt_d   = '0;
        end
      end
      S_OFF: begin
        cmd_o.op  = cnt_q[0] ? OP_OFF_ACC : OP_OFF_MUL;
        cmd_o.idx = cnt_q[3:1];
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'd5) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      vsel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      vsel_q  <= vsel_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.in_ready |-> state_q == S_IDLE)
    else $error("input taken outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT && cnt_q == 5'(SqrtSteps - 1)) |=> state_q == S_DIV_INIT)
    else $error("root not followed by division");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_DIV_STORE |-> comp_q != 2'd3)
    else $error("component index out of range");

endmodule

// ===== hw/rtl/pre_dp.sv =====
// Datapath of the ribbon extruder: point history, normals, shared multiplier,
// bit-serial square root and divider, output register. Depends on pre_pkg, pre_if.
module pre_dp
  import pre_pkg::*;
#(
  parameter int unsigned CoordFracBits = CoordFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LwWidth-1:0]  cfg_wdata_i,
  input  pre_cmd_t            cmd_i,
  output pre_stat_t           stat_o,
  pre_point_if.sink           pt_i,
  pre_result_if.source        res_o
);

  localparam longint unsigned LwRaw = ((64'd1 << CoordFracBits) * 64'd25 + 64'd500) / 64'd1000;
  localparam logic [LwWidth-1:0] LwReset = (LwRaw > 64'd4095) ? 12'd4095 : LwRaw[LwWidth-1:0];

  logic [LwWidth-1:0] lw_q;
  logic signed [15:0] older_q [3];
  logic signed [15:0] newer_q [3];
  logic signed [15:0] p_q [3];
  logic [1:0]         seen_q;
  logic signed [15:0] side_q [3];
  logic signed [15:0] smooth_q [3];
  logic               fell_q;
  logic               valid_q;

  logic signed [16:0] a_q [3];
  logic signed [16:0] b_q [3];
  logic signed [17:0] sum_q [3];
  logic signed [34:0] c_q [3];
  logic [34:0]        m_q [3];
  logic               neg_q [3];
  logic signed [41:0] prod_q;
  logic [41:0]        len2_q;
  logic [62:0]        rad_q, root_q, bit_q;
  logic [44:0]        rem_q;
  logic [46:0]        dsr_q;
  logic [15:0]        quo_q;
  logic signed [15:0] up_q [3];
  logic signed [15:0] lo_q [3];

  logic signed [15:0] pin [3];
  logic               acc;
  logic [1:0]         ci;
  logic signed [20:0] mul_a, mul_b;
  logic signed [41:0] prod_d;
  logic [62:0]        trial;
  logic [14:0]        qcap;
  logic [26:0]        pabs;
  logic [12:0]        pmag;
  logic signed [18:0] off;
  logic signed [18:0] upper_w, lower_w;

  assign pin[0] = pt_i.point_x;
  assign pin[1] = pt_i.point_y;
  assign pin[2] = pt_i.point_z;
  assign acc    = pt_i.valid && cmd_i.in_ready;
  assign ci     = cmd_i.idx[1:0];
  assign pt_i.ready = cmd_i.in_ready;

  assign stat_o.in_valid    = pt_i.valid;
  assign stat_o.strip_start = pt_i.strip_start;
  assign stat_o.seen        = seen_q;
  assign stat_o.big         = (|m_q[0][34:20]) || (|m_q[1][34:20]) || (|m_q[2][34:20]);
  assign stat_o.len_zero    = (len2_q == '0);
  assign stat_o.out_busy    = valid_q && !res_o.ready;

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_CROSS_MUL: begin
        // c0 = a1*b2 - a2*b1, c1 = a2*b0 - a0*b2, c2 = a0*b1 - a1*b0
        case (cmd_i.idx)
          3'd0: begin mul_a = 21'(a_q[1]); mul_b = 21'(b_q[2]); end
          3'd1: begin mul_a = 21'(a_q[2]); mul_b = 21'(b_q[1]); end
          3'd2: begin mul_a = 21'(a_q[2]); mul_b = 21'(b_q[0]); end
          3'd3: begin mul_a = 21'(a_q[0]); mul_b = 21'(b_q[2]); end
          3'd4: begin mul_a = 21'(a_q[0]); mul_b = 21'(b_q[1]); end
          3'd5: begin mul_a = 21'(a_q[1]); mul_b = 21'(b_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      OP_SQ_MUL: begin
        mul_a = signed'({1'b0, m_q[ci][19:0]});
        mul_b = signed'({1'b0, m_q[ci][19:0]});
      end
      OP_OFF_MUL: begin
        mul_a = 21'(side_q[ci]);
        mul_b = signed'({9'd0, lw_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign trial  = root_q + bit_q;
  assign qcap   = (quo_q > 16'd16384) ? 15'd16384 : quo_q[14:0];

  // rounded offset, half away from zero
  assign pabs    = prod_q[41] ? 27'(-prod_q) : prod_q[26:0];
  assign pmag    = 13'((28'(pabs) + 28'd8192) >> 14);
  assign off     = prod_q[41] ? -signed'({6'd0, pmag}) : signed'({6'd0, pmag});
  assign upper_w = 19'(newer_q[ci]) + off;
  assign lower_w = 19'(newer_q[ci]) - off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q     <= LwReset;
      seen_q   <= '0;
      valid_q  <= 1'b0;
      fell_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        older_q[i] <= '0;
        newer_q[i] <= '0;
      end
      side_q   <= '{16'sd0, UnitOne, 16'sd0};
      smooth_q <= '{16'sd0, 16'sd0, UnitOne};
    end else begin
      if (cfg_we_i) begin
        lw_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_EMIT) begin
        valid_q <= 1'b1;
      end else if (valid_q && res_o.ready) begin
        valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_START: begin
          if (acc) begin
            for (int i = 0; i < 3; i++) begin
              older_q[i] <= '0;
              newer_q[i] <= pin[i];
            end
            seen_q   <= 2'd1;
            side_q   <= '{16'sd0, UnitOne, 16'sd0};
            smooth_q <= '{16'sd0, 16'sd0, UnitOne};
          end
        end
        OP_SHIFT: begin
          if (acc) begin
            for (int i = 0; i < 3; i++) begin
              older_q[i] <= newer_q[i];
              newer_q[i] <= pin[i];
            end
            seen_q <= 2'd2;
          end
        end
        OP_LOAD: begin
          if (acc) begin
            fell_q <= 1'b0;
          end
        end
        OP_SIDE_FALL, OP_SMOOTH_FALL: begin
          fell_q <= 1'b1;
        end
        OP_DIV_STORE: begin
          if (cmd_i.vsel) begin
            smooth_q[ci] <= neg_q[ci] ? -signed'({1'b0, qcap}) : signed'({1'b0, qcap});
          end else begin
            side_q[ci] <= neg_q[ci] ? -signed'({1'b0, qcap}) : signed'({1'b0, qcap});
          end
        end
        OP_EMIT: begin
          for (int i = 0; i < 3; i++) begin
            older_q[i] <= newer_q[i];
            newer_q[i] <= p_q[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          p_q[i]   <= pin[i];
          a_q[i]   <= 17'(newer_q[i]) - 17'(older_q[i]);
          b_q[i]   <= 17'(newer_q[i]) - 17'(pin[i]);
          sum_q[i] <= 18'(newer_q[i]) - 18'(older_q[i]) + 18'(newer_q[i]) - 18'(pin[i]);
        end
      end
      OP_CROSS_MUL, OP_SQ_MUL, OP_OFF_MUL: begin
        prod_q <= prod_d;
      end
      OP_CROSS_ACC: begin
        if (cmd_i.idx[0]) begin
          c_q[cmd_i.idx[2:1]] <= c_q[cmd_i.idx[2:1]] - prod_q[34:0];
        end else begin
          c_q[cmd_i.idx[2:1]] <= prod_q[34:0];
        end
      end
      OP_VEC_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          if (cmd_i.vsel) begin
            neg_q[i] <= sum_q[i][17];
            m_q[i]   <= sum_q[i][17] ? 35'(-sum_q[i]) : 35'(sum_q[i]);
          end else begin
            neg_q[i] <= c_q[i][34];
            m_q[i]   <= c_q[i][34] ? 35'(-c_q[i]) : 35'(c_q[i]);
          end
        end
      end
      OP_HALVE: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i] <= m_q[i] >> 1;
        end
      end
      OP_SQ_ACC: begin
        len2_q <= (ci == 2'd0) ? prod_q[41:0] : len2_q + prod_q[41:0];
      end
      OP_SQRT_INIT: begin
        rad_q  <= {1'b0, len2_q, 20'd0};
        root_q <= '0;
        bit_q  <= 63'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (rad_q >= trial) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DIV_INIT: begin
        rem_q <= {1'b0, m_q[ci][19:0], 24'd0} + 45'(root_q[31:1]);
        dsr_q <= {root_q[31:0], 15'd0};
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        if ({2'b00, rem_q} >= dsr_q) begin
          rem_q <= rem_q - dsr_q[44:0];
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          quo_q <= {quo_q[14:0], 1'b0};
        end
        dsr_q <= dsr_q >> 1;
      end
      OP_OFF_ACC: begin
        up_q[ci] <= sat16(upper_w);
        lo_q[ci] <= sat16(lower_w);
      end
      OP_EMIT: begin
        res_o.upper_x  <= up_q[0];
        res_o.upper_y  <= up_q[1];
        res_o.upper_z  <= up_q[2];
        res_o.lower_x  <= lo_q[0];
        res_o.lower_y  <= lo_q[1];
        res_o.lower_z  <= lo_q[2];
        res_o.smooth_x <= smooth_q[0];
        res_o.smooth_y <= smooth_q[1];
        res_o.smooth_z <= smooth_q[2];
        res_o.fell_back <= fell_q;
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid = valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_EMIT |-> !stat_o.out_busy)
    else $error("result overwritten while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_SQRT_INIT |-> len2_q != '0)
    else $error("root of a degenerate vector");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(cmd_i.op == OP_EMIT))
    else $error("result valid without emit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd_i.op == OP_START) |=> seen_q == 2'd1)
    else $error("strip start did not open a strip");

endmodule

// ===== sim/pre_ribbon_checker.sv =====
// Ribbon result checker: tracks accepted points, predicts each ribbon result
// and compares it with the result channel. Depends on pre_pkg and pre_if.
module pre_ribbon_checker
  import pre_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LwWidth-1:0] cfg_wdata_i,
  pre_point_if               pt,
  pre_result_if              res,
  output int                 err_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] ux, uy, uz, lx, ly, lz, sx, sy, sz;
    logic               fb;
  } ribbon_t;

  ribbon_t ribbon_q[$];
  logic [LwWidth-1:0] width_q;
  int signed older_p[3], newer_p[3];
  int unsigned seen;
  int signed side_hold[3], smooth_hold[3];

  assign pending_o = ribbon_q.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("checker: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count_o++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  // Unit vector in Q1.14; returns 0 when the vector has no length.
  function automatic bit make_unit(input longint v[3], output int signed u[3]);
    logic [63:0] m[3], mx, len2, s, q;
    for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
    forever begin
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx < (64'd1 << 20)) break;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    if (len2 == 0) return 0;
    s = int_sqrt(len2 << 20);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 24) + s / 2) / s;
      if (q > 16384) q = 16384;
      u[i] = v[i] < 0 ? -int'(q) : int'(q);
    end
    return 1;
  endfunction

  function automatic int signed clamp16(input int signed v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void reset_normals();
    side_hold = '{0, 16384, 0};
    smooth_hold = '{0, 0, 16384};
  endfunction

  task automatic extrude_point(input int signed p[3], input bit start);
    longint a[3], b[3], c[3], sm[3];
    int signed side[3], smooth[3], edge_up[3], edge_dn[3];
    int signed prod, off;
    int unsigned mag;
    bit side_ok, smooth_ok;
    ribbon_t r;
    if (start || seen == 0) begin
      older_p = '{0, 0, 0};
      newer_p = p;
      seen = 1;
      reset_normals();
      return;
    end
    if (seen == 1) begin
      older_p = newer_p;
      newer_p = p;
      seen = 2;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      a[i] = newer_p[i] - older_p[i];
      b[i] = newer_p[i] - p[i];
      sm[i] = a[i] + b[i];
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    side_ok = make_unit(c, side);
    if (!side_ok) side = side_hold;
    smooth_ok = side_ok && make_unit(sm, smooth);
    if (!smooth_ok) smooth = smooth_hold;
    for (int i = 0; i < 3; i++) begin
      prod = side[i] * int'(width_q);
      mag = (unsigned'(prod < 0 ? -prod : prod) + 8192) >> 14;
      off = prod < 0 ? -int'(mag) : int'(mag);
      edge_up[i] = clamp16(newer_p[i] + off);
      edge_dn[i] = clamp16(newer_p[i] - off);
    end
    side_hold = side;
    smooth_hold = smooth;
    r.ux = 16'(edge_up[0]); r.uy = 16'(edge_up[1]); r.uz = 16'(edge_up[2]);
    r.lx = 16'(edge_dn[0]); r.ly = 16'(edge_dn[1]); r.lz = 16'(edge_dn[2]);
    r.sx = 16'(smooth[0]); r.sy = 16'(smooth[1]); r.sz = 16'(smooth[2]);
    r.fb = !(side_ok && smooth_ok);
    ribbon_q.push_back(r);
    older_p = newer_p;
    newer_p = p;
  endtask

  task automatic compare_ribbon();
    ribbon_t w;
    if (ribbon_q.size() == 0) begin
      report_mismatch("unexpected result, upper_x", res.upper_x, 0);
      return;
    end
    w = ribbon_q.pop_front();
    if (res.upper_x !== w.ux) report_mismatch("upper_x", res.upper_x, w.ux);
    if (res.upper_y !== w.uy) report_mismatch("upper_y", res.upper_y, w.uy);
    if (res.upper_z !== w.uz) report_mismatch("upper_z", res.upper_z, w.uz);
    if (res.lower_x !== w.lx) report_mismatch("lower_x", res.lower_x, w.lx);
    if (res.lower_y !== w.ly) report_mismatch("lower_y", res.lower_y, w.ly);
    if (res.lower_z !== w.lz) report_mismatch("lower_z", res.lower_z, w.lz);
    if (res.smooth_x !== w.sx) report_mismatch("smooth_x", res.smooth_x, w.sx);
    if (res.smooth_y !== w.sy) report_mismatch("smooth_y", res.smooth_y, w.sy);
    if (res.smooth_z !== w.sz) report_mismatch("smooth_z", res.smooth_z, w.sz);
    if (res.fell_back !== w.fb) report_mismatch("fell_back", res.fell_back, w.fb);
  endtask

  initial err_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    int signed p[3];
    if (!rst_ni) begin
      width_q = 12'd102;
      older_p = '{0, 0, 0};
      newer_p = '{0, 0, 0};
      seen = 0;
      reset_normals();
      ribbon_q.delete();
    end else begin
      if (res.valid === 1'b1 && res.ready === 1'b1) compare_ribbon();
      if (pt.valid === 1'b1 && pt.ready === 1'b1) begin
        p = '{pt.point_x, pt.point_y, pt.point_z};
        extrude_point(p, pt.strip_start);
      end
      if (cfg_we_i) width_q = cfg_wdata_i;
    end
  end

endmodule

// ===== sim/tb_polyline_ribbon_extruder.sv =====
// Testbench top: clock, reset, point stimulus, result back-pressure, verdict.
// Depends on pre_pkg, pre_if, pre_ribbon_checker and the extruder RTL.
module tb_polyline_ribbon_extruder;
  import pre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [LwWidth-1:0] cfg_wdata_i = '0;
  int                 err_count;
  int                 pending;
  int                 idle_cycles = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;

  pre_point_if  pt();
  pre_result_if res();

  polyline_ribbon_extruder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pt_i       (pt),
    .res_o      (res)
  );

  pre_ribbon_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pt         (pt),
    .res        (res),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.point_z = '0;
    pt.strip_start = 1'b0;
    res.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((pt.valid && pt.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_polyline_ribbon_extruder: errors");
        $finish;
      end
    end
  end

  // One point; waits until it is taken. Random idle cycles come first.
  // valid stays high after the item so that items can follow back to back.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic signed [15:0] z, input bit start);
    while ($urandom_range(99) < send_idle_pct) begin
      pt.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt.valid <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    pt.point_z <= z;
    pt.strip_start <= start;
    do @(posedge clk_i); while (!pt.ready);
  endtask

  task automatic drain_and_write(input logic [LwWidth-1:0] w);
    pt.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_coord(input int unsigned span);
    case ($urandom_range(5))
      0: return 16'($urandom());
      1: return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
      default: return $signed(16'($urandom_range(2 * span))) - $signed(16'(span));
    endcase
  endfunction

  task automatic random_strips(input int n_items);
    int sent, len;
    logic signed [15:0] x, y, z;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(12, 2);
      x = rand_coord(8000);
      y = rand_coord(8000);
      z = rand_coord(8000);
      send_point(x, y, z, $urandom_range(9) != 0);
      for (int k = 1; k < len; k++) begin
        case ($urandom_range(9))
          0: ;                          // repeated point
          1: begin x = 16'(x + 16'sd100); end     // collinear-ish step
          2: begin x = rand_coord(30000); y = rand_coord(30000); z = rand_coord(30000); end
          default: begin
            x = 16'(x + $signed(16'($urandom_range(1200))) - 16'sd600);
            y = 16'(y + $signed(16'($urandom_range(1200))) - 16'sd600);
            z = 16'(z + $signed(16'($urandom_range(1200))) - 16'sd600);
          end
        endcase
        send_point(x, y, z, 1'b0);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first point without a strip start, second point, straight
    // line and U-turn (both side fallback), extremes with saturation.
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd4096, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd8192, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd8192, 16'sd4096, 16'sd0, 1'b0);
    send_point(16'sd8192, 16'sd4096, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd4096, 16'sd4096, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd4096, 1'b0);
    drain_and_write(12'd4095);
    send_point(-16'sh8000, -16'sh8000, -16'sh8000, 1'b1);
    send_point(16'sh7fff, -16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, -16'sh8000, 1'b0);
    send_point(-16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh5555, -16'sh2aab, 16'sh0001, 1'b0);
    drain_and_write(12'd0);
    send_point(16'sd100, 16'sd200, 16'sd300, 1'b1);
    send_point(16'sd400, 16'sd100, -16'sd300, 1'b0);
    send_point(-16'sd50, 16'sd700, 16'sd10, 1'b0);

    // Random phases with different idling and widths.
    drain_and_write(12'd102);
    random_strips(350);
    send_idle_pct = 60;
    drain_and_write(12'($urandom()));
    random_strips(350);
    send_idle_pct = 0;
    recv_stall_pct = 60;
    drain_and_write(12'd4095);
    random_strips(350);
    send_idle_pct = 35;
    recv_stall_pct = 35;
    drain_and_write(12'd1);
    random_strips(350);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_and_write(12'($urandom()));
    random_strips(300);

    pt.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_polyline_ribbon_extruder: clean");
    end else begin
      $display("tb_polyline_ribbon_extruder: errors");
    end
    $finish;
  end

endmodule
